[sv/agsb_pkg.sv]
// Package for the ack gap scoreboard: payload structs, field widths,
// mode/status/register codes, datapath command and status types.
// No dependencies.
package agsb_pkg;

    localparam int LEN_W    = 24;
    localparam int EPOCH_W  = 64;
    localparam int SEQ_W    = 48;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_IX_W = 2;
    localparam int PIECE_W  = 6;   // piece counter, up to MAX_PIECES - 1
    localparam int MAX_PIECES = 64;
    localparam logic [LEN_W-1:0] MAX_FRAG_RESET = 24'd1024;

    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [CFG_IX_W-1:0] cfg_index_t;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_SENT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MAP_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_GAP_FULL = 2'd2;

    // Configuration register indexes
    localparam cfg_index_t REG_TOTAL_LENGTH = 2'd0;
    localparam cfg_index_t REG_MAX_FRAGMENT = 2'd1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [EPOCH_W-1:0] epoch;
        logic [SEQ_W-1:0]   sequence_number;
        len_t               fragment_offset;
        len_t               fragment_length;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        len_t              unacked_count;
        logic              all_acked;
        len_t              piece_offset;
        len_t              piece_length;
        logic              last;
        logic              truncated;
    } out_item_t;

    typedef struct packed {
        len_t start;
        len_t stop;
    } gap_entry_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [SEQ_W-1:0]   sequence_number;
        len_t               offset;
        len_t               length;
    } map_entry_t;

    // Where a gap lies against the ack range [a, b)
    typedef enum logic [2:0] {
        GC_BELOW,
        GC_ABOVE,
        GC_COVER,
        GC_FRONT,
        GC_BACK,
        GC_SPLIT
    } gap_class_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAP_RD,
        OP_MAP_NEXT,
        OP_MAP_WR,
        OP_SET_MAP_FULL,
        OP_ACK_SET,
        OP_GAP_RD,
        OP_GAP_NEXT,
        OP_DEL_START,
        OP_DEL_RD,
        OP_DEL_WR,
        OP_DEL_DONE,
        OP_TRIM_FRONT,
        OP_TRIM_BACK,
        OP_SET_GAP_FULL,
        OP_SPLIT_SAVE,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_HI,
        OP_INS_LO,
        OP_Q_LOAD,
        OP_PIECE,
        OP_ADV,
        OP_FINAL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              map_end;
        logic              map_full;
        logic              map_hit;
        logic              ack_empty;
        logic              gap_end;
        logic              gap_full;
        logic              gap_none;
        logic              del_more;
        logic              ins_more;
        logic              gap_done;
        logic              out_last;
        gap_class_t        cls;
    } dp_stat_t;

    typedef enum logic [4:0] {
        FSM_IDLE,
        FSM_MAP_RD,
        FSM_MAP_CMP,
        FSM_ACK_CHK,
        FSM_GAP_RD,
        FSM_GAP_EV,
        FSM_DEL_CHK,
        FSM_DEL_WR,
        FSM_INS_CHK,
        FSM_INS_WR,
        FSM_INS_LO,
        FSM_Q_RD,
        FSM_Q_LD,
        FSM_Q_PC,
        FSM_RESULT,
        FSM_OUT
    } fsm_state_t;

endpackage

[sv/ack_gap_scoreboard_unit.sv]
// Ack gap scoreboard: tracks unacknowledged byte ranges of one message.
// Input channel s_valid/s_ready/s_data carries one command per beat:
// mode 0 maps a sent record to its fragment, mode 1 acknowledges a record
// and removes its range from the gap table, mode 2 lists the missing
// pieces. The result channel m_valid/m_ready/m_data returns one beat for
// modes 0, 1 and 3, and one beat per piece (1 to 64) for mode 2; the final
// beat has last set, or truncated set when the listing stops at 64 pieces.
// The config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes total
// length (index 0, restarts the table and map) or max fragment length
// (index 1); it is accepted only while no item is in work.
// One item is in work at a time. The record map is searched one entry at
// a time, read in FSM_MAP_RD and compared in FSM_MAP_CMP; each gap edit
// visits the gaps in order and shifts gap table entries one by one. Mode 2
// reads each gap and then lists its pieces one beat at a time.
// After reset: total length 0, max fragment 1024, table and map empty.
// While the receiver holds m_ready low the result beat holds and no new
// item is accepted.
module ack_gap_scoreboard_unit #(
    parameter int GAP_SLOTS = 16,
    parameter int MAP_SLOTS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  agsb_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output agsb_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  agsb_pkg::cfg_index_t cfg_index,
    input  agsb_pkg::len_t       cfg_data
);

    agsb_pkg::dp_cmd_t  cmd;
    agsb_pkg::dp_stat_t stat;
    agsb_pkg::dp_stat_t stat_ctrl;

    // The mode steering the first step comes straight from the input beat
    always_comb begin
        stat_ctrl = stat;
        if (s_ready) begin
            stat_ctrl.mode = s_data.mode;
        end
    end

    agsb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat_ctrl),
        .cmd       (cmd)
    );

    agsb_datapath #(
        .GAP_SLOTS (GAP_SLOTS),
        .MAP_SLOTS (MAP_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (m_data)
    );

endmodule

[sv/agsb_datapath.sv]
// Datapath of the ack gap scoreboard: record map and gap table memories,
// counters, range arithmetic and the result register.
// Depends on agsb_pkg; driven by agsb_ctrl through dp_cmd_t.
module agsb_datapath #(
    parameter int GAP_SLOTS = 16,
    parameter int MAP_SLOTS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  agsb_pkg::cfg_index_t cfg_index,
    input  agsb_pkg::len_t       cfg_data,
    input  agsb_pkg::in_item_t   in_item,
    input  agsb_pkg::dp_cmd_t    cmd,
    output agsb_pkg::dp_stat_t   stat,
    output agsb_pkg::out_item_t  out_item
);

    localparam int GIW = $clog2(GAP_SLOTS + 2);
    localparam int GAW = $clog2(GAP_SLOTS);
    localparam int MCW = $clog2(MAP_SLOTS + 1);
    localparam int MAW = $clog2(MAP_SLOTS);

    // Memories
    agsb_pkg::gap_entry_t gap_mem [GAP_SLOTS];
    agsb_pkg::map_entry_t map_mem [MAP_SLOTS];

    // Registers
    agsb_pkg::len_t      total_reg, mfrag_reg, unacked_reg;
    agsb_pkg::len_t      total_next, mfrag_next, unacked_next;
    logic [GIW-1:0]      gcount_reg, gcount_next;
    logic [GIW-1:0]      i_reg, i_next, k_reg, k_next;
    logic [MCW-1:0]      mcount_reg, mcount_next, j_reg, j_next;
    agsb_pkg::in_item_t  item_reg, item_next;
    agsb_pkg::len_t      a_reg, a_next, b_reg, b_next;
    logic                empty_reg, empty_next;
    agsb_pkg::gap_entry_t gq_reg, sav_reg, sav_next;
    agsb_pkg::map_entry_t mq_reg;
    agsb_pkg::len_t      cur_reg, cur_next, stop_reg, stop_next, pl_reg, pl_next;
    logic [agsb_pkg::PIECE_W-1:0] n_reg, n_next;
    logic [agsb_pkg::STAT_W-1:0]  st_reg, st_next;
    agsb_pkg::out_item_t out_reg, out_next;

    // Memory ports
    logic                 gap_we, gap_re, map_we, map_re;
    logic [GAW-1:0]       gap_waddr, gap_raddr;
    agsb_pkg::gap_entry_t gap_wdata;

    // Helpers
    agsb_pkg::len_t   mf, rem, pl_c, sum_pc;
    logic [agsb_pkg::LEN_W:0] ack_sum;
    agsb_pkg::len_t   ack_b;
    logic             more_c;
    agsb_pkg::gap_class_t cls_c;

    // Effective fragment limit and piece size
    assign mf     = (mfrag_reg == '0) ? agsb_pkg::len_t'(1) : mfrag_reg;
    assign rem    = stop_reg - cur_reg;
    assign pl_c   = (rem > mf) ? mf : rem;
    assign more_c = (cur_reg + pl_c != stop_reg) || ((i_reg + GIW'(1)) < gcount_reg);
    assign sum_pc = cur_reg + pl_reg;

    // Ack range from the record that was hit, clipped to total length
    assign ack_sum = {1'b0, mq_reg.offset} + {1'b0, mq_reg.length};
    assign ack_b   = (ack_sum > {1'b0, total_reg}) ? total_reg
                                                   : ack_sum[agsb_pkg::LEN_W-1:0];

    // Gap position against [a, b)
    always_comb begin
        if (gq_reg.stop <= a_reg) begin
            cls_c = agsb_pkg::GC_BELOW;
        end else if (gq_reg.start >= b_reg) begin
            cls_c = agsb_pkg::GC_ABOVE;
        end else if (gq_reg.start >= a_reg && gq_reg.stop <= b_reg) begin
            cls_c = agsb_pkg::GC_COVER;
        end else if (gq_reg.start >= a_reg) begin
            cls_c = agsb_pkg::GC_FRONT;
        end else if (gq_reg.stop <= b_reg) begin
            cls_c = agsb_pkg::GC_BACK;
        end else begin
            cls_c = agsb_pkg::GC_SPLIT;
        end
    end

    // Status to the controller
    always_comb begin
        stat.mode      = item_reg.mode;
        stat.map_end   = (j_reg >= mcount_reg);
        stat.map_full  = (mcount_reg >= MCW'(MAP_SLOTS));
        stat.map_hit   = (mq_reg.epoch == item_reg.epoch) &&
                         (mq_reg.sequence_number == item_reg.sequence_number);
        stat.ack_empty = empty_reg;
        stat.gap_end   = (i_reg >= gcount_reg);
        stat.gap_full  = (gcount_reg >= GIW'(GAP_SLOTS));
        stat.gap_none  = (gcount_reg == '0);
        stat.del_more  = ((k_reg + GIW'(1)) < gcount_reg);
        stat.ins_more  = (k_reg > (i_reg + GIW'(1)));
        stat.gap_done  = (sum_pc == stop_reg);
        // a truncated listing ends on its flagged beat
        stat.out_last  = out_reg.last || out_reg.truncated;
        stat.cls       = cls_c;
    end

    assign out_item = out_reg;

    // Next-state logic per command
    always_comb begin
        total_next   = total_reg;
        mfrag_next   = mfrag_reg;
        unacked_next = unacked_reg;
        gcount_next  = gcount_reg;
        mcount_next  = mcount_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        item_next    = item_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        empty_next   = empty_reg;
        sav_next     = sav_reg;
        cur_next     = cur_reg;
        stop_next    = stop_reg;
        pl_next      = pl_reg;
        n_next       = n_reg;
        st_next      = st_reg;
        out_next     = out_reg;
        gap_we       = 1'b0;
        gap_re       = 1'b0;
        map_we       = 1'b0;
        map_re       = 1'b0;
        gap_waddr    = i_reg[GAW-1:0];
        gap_raddr    = i_reg[GAW-1:0];
        gap_wdata    = gq_reg;

        case (cmd.op)
            agsb_pkg::OP_LOAD: begin
                item_next = in_item;
                i_next    = '0;
                j_next    = '0;
                n_next    = '0;
                st_next   = agsb_pkg::STAT_OK;
            end
            agsb_pkg::OP_MAP_RD: begin
                map_re = 1'b1;
            end
            agsb_pkg::OP_MAP_NEXT: begin
                j_next = j_reg + MCW'(1);
            end
            agsb_pkg::OP_MAP_WR: begin
                map_we      = 1'b1;
                mcount_next = mcount_reg + MCW'(1);
            end
            agsb_pkg::OP_SET_MAP_FULL: begin
                st_next = agsb_pkg::STAT_MAP_FULL;
            end
            agsb_pkg::OP_ACK_SET: begin
                a_next     = mq_reg.offset;
                b_next     = ack_b;
                empty_next = (mq_reg.length == '0) || (mq_reg.offset >= total_reg);
            end
            agsb_pkg::OP_GAP_RD: begin
                gap_re = 1'b1;
            end
            agsb_pkg::OP_GAP_NEXT: begin
                i_next = i_reg + GIW'(1);
            end
            agsb_pkg::OP_DEL_START: begin
                unacked_next = unacked_reg - (gq_reg.stop - gq_reg.start);
                k_next       = i_reg;
            end
            agsb_pkg::OP_DEL_RD: begin
                gap_re    = 1'b1;
                gap_raddr = GAW'(k_reg + GIW'(1));
            end
            agsb_pkg::OP_DEL_WR: begin
                gap_we    = 1'b1;
                gap_waddr = k_reg[GAW-1:0];
                gap_wdata = gq_reg;
                k_next    = k_reg + GIW'(1);
            end
            agsb_pkg::OP_DEL_DONE: begin
                gcount_next = gcount_reg - GIW'(1);
            end
            agsb_pkg::OP_TRIM_FRONT: begin
                gap_we       = 1'b1;
                gap_wdata    = '{start: b_reg, stop: gq_reg.stop};
                unacked_next = unacked_reg - (b_reg - gq_reg.start);
                i_next       = i_reg + GIW'(1);
            end
            agsb_pkg::OP_TRIM_BACK: begin
                gap_we       = 1'b1;
                gap_wdata    = '{start: gq_reg.start, stop: a_reg};
                unacked_next = unacked_reg - (gq_reg.stop - a_reg);
                i_next       = i_reg + GIW'(1);
            end
            agsb_pkg::OP_SET_GAP_FULL: begin
                st_next = agsb_pkg::STAT_GAP_FULL;
            end
            agsb_pkg::OP_SPLIT_SAVE: begin
                sav_next = gq_reg;
                k_next   = gcount_reg;
            end
            agsb_pkg::OP_INS_RD: begin
                gap_re    = 1'b1;
                gap_raddr = GAW'(k_reg - GIW'(1));
            end
            agsb_pkg::OP_INS_WR: begin
                gap_we    = 1'b1;
                gap_waddr = k_reg[GAW-1:0];
                gap_wdata = gq_reg;
                k_next    = k_reg - GIW'(1);
            end
            agsb_pkg::OP_INS_HI: begin
                gap_we    = 1'b1;
                gap_waddr = GAW'(i_reg + GIW'(1));
                gap_wdata = '{start: b_reg, stop: sav_reg.stop};
            end
            agsb_pkg::OP_INS_LO: begin
                gap_we       = 1'b1;
                gap_wdata    = '{start: sav_reg.start, stop: a_reg};
                gcount_next  = gcount_reg + GIW'(1);
                unacked_next = unacked_reg - (b_reg - a_reg);
                i_next       = i_reg + GIW'(2);
            end
            agsb_pkg::OP_Q_LOAD: begin
                cur_next  = gq_reg.start;
                stop_next = gq_reg.stop;
            end
            agsb_pkg::OP_PIECE: begin
                pl_next = pl_c;
                out_next.status        = agsb_pkg::STAT_OK;
                out_next.unacked_count = unacked_reg;
                out_next.all_acked     = (unacked_reg == '0);
                out_next.piece_offset  = cur_reg;
                out_next.piece_length  = pl_c;
                // the 64th beat of a cut listing carries truncated, not last
                out_next.last          = !more_c;
                out_next.truncated     = more_c &&
                                         (n_reg == agsb_pkg::PIECE_W'(agsb_pkg::MAX_PIECES - 1));
            end
            agsb_pkg::OP_ADV: begin
                cur_next = sum_pc;
                n_next   = n_reg + agsb_pkg::PIECE_W'(1);
                if (sum_pc == stop_reg) begin
                    i_next = i_reg + GIW'(1);
                end
            end
            agsb_pkg::OP_FINAL: begin
                out_next.status        = st_reg;
                out_next.unacked_count = unacked_reg;
                out_next.all_acked     = (unacked_reg == '0);
                out_next.piece_offset  = '0;
                out_next.piece_length  = '0;
                out_next.last          = 1'b1;
                out_next.truncated     = 1'b0;
            end
            default: begin
            end
        endcase

        // Configuration writes, taken only while idle
        if (cfg_we) begin
            case (cfg_index)
                agsb_pkg::REG_TOTAL_LENGTH: begin
                    total_next   = cfg_data;
                    unacked_next = cfg_data;
                    mcount_next  = '0;
                    gcount_next  = (cfg_data != '0) ? GIW'(1) : '0;
                    gap_we       = 1'b1;
                    gap_waddr    = '0;
                    gap_wdata    = '{start: '0, stop: cfg_data};
                end
                agsb_pkg::REG_MAX_FRAGMENT: begin
                    mfrag_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            mfrag_reg   <= agsb_pkg::MAX_FRAG_RESET;
            unacked_reg <= '0;
            gcount_reg  <= '0;
            mcount_reg  <= '0;
        end else begin
            total_reg   <= total_next;
            mfrag_reg   <= mfrag_next;
            unacked_reg <= unacked_next;
            gcount_reg  <= gcount_next;
            mcount_reg  <= mcount_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        k_reg     <= k_next;
        j_reg     <= j_next;
        item_reg  <= item_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        empty_reg <= empty_next;
        sav_reg   <= sav_next;
        cur_reg   <= cur_next;
        stop_reg  <= stop_next;
        pl_reg    <= pl_next;
        n_reg     <= n_next;
        st_reg    <= st_next;
        out_reg   <= out_next;
    end

    // Gap table memory
    always_ff @(posedge aclk) begin
        if (gap_we) begin
            gap_mem[gap_waddr] <= gap_wdata;
        end
        if (gap_re) begin
            gq_reg <= gap_mem[gap_raddr];
        end
    end

    // Record map memory
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[mcount_reg[MAW-1:0]] <= '{epoch: item_reg.epoch,
                                              sequence_number: item_reg.sequence_number,
                                              offset: item_reg.fragment_offset,
                                              length: item_reg.fragment_length};
        end
        if (map_re) begin
            mq_reg <= map_mem[j_reg[MAW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_gcount_max: assert property (@(posedge aclk) disable iff (!aresetn)
        gcount_reg <= GIW'(GAP_SLOTS))
        else $error("gap count above table size");
    a_mcount_max: assert property (@(posedge aclk) disable iff (!aresetn)
        mcount_reg <= MCW'(MAP_SLOTS))
        else $error("record count above map size");
    a_unacked_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        unacked_reg <= total_reg)
        else $error("unacked bytes exceed total length");
`endif

endmodule

[sv/agsb_ctrl.sv]
// Controller state machine of the ack gap scoreboard: sequences map search,
// gap table edits, piece listing and result handshake.
// Depends on agsb_pkg; commands agsb_datapath.
module agsb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  agsb_pkg::dp_stat_t stat,
    output agsb_pkg::dp_cmd_t  cmd
);

    agsb_pkg::fsm_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= agsb_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd.op     = agsb_pkg::OP_NONE;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cfg_ready  = 1'b0;

        case (state_reg)
            agsb_pkg::FSM_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (s_valid && !cfg_valid) begin
                    cmd.op = agsb_pkg::OP_LOAD;
                    case (1'b1)
                        (stat.mode == agsb_pkg::MODE_SENT),
                        (stat.mode == agsb_pkg::MODE_ACK): begin
                            state_next = agsb_pkg::FSM_MAP_RD;
                        end
                        default: begin
                            state_next = agsb_pkg::FSM_RESULT;
                        end
                    endcase
                end
            end
            agsb_pkg::FSM_MAP_RD: begin
                if (stat.map_end) begin
                    if (stat.mode == agsb_pkg::MODE_SENT) begin
                        cmd.op = stat.map_full ? agsb_pkg::OP_SET_MAP_FULL
                                               : agsb_pkg::OP_MAP_WR;
                    end
                    state_next = agsb_pkg::FSM_RESULT;
                end else begin
                    cmd.op     = agsb_pkg::OP_MAP_RD;
                    state_next = agsb_pkg::FSM_MAP_CMP;
                end
            end
            agsb_pkg::FSM_MAP_CMP: begin
                if (!stat.map_hit) begin
                    cmd.op     = agsb_pkg::OP_MAP_NEXT;
                    state_next = agsb_pkg::FSM_MAP_RD;
                end else if (stat.mode == agsb_pkg::MODE_ACK) begin
                    cmd.op     = agsb_pkg::OP_ACK_SET;
                    state_next = agsb_pkg::FSM_ACK_CHK;
                end else begin
                    state_next = agsb_pkg::FSM_RESULT;
                end
            end
            agsb_pkg::FSM_ACK_CHK: begin
                state_next = stat.ack_empty ? agsb_pkg::FSM_RESULT : agsb_pkg::FSM_GAP_RD;
            end
            agsb_pkg::FSM_GAP_RD: begin
                if (stat.gap_end) begin
                    state_next = agsb_pkg::FSM_RESULT;
                end else begin
                    cmd.op     = agsb_pkg::OP_GAP_RD;
                    state_next = agsb_pkg::FSM_GAP_EV;
                end
            end
            agsb_pkg::FSM_GAP_EV: begin
                case (stat.cls)
                    agsb_pkg::GC_BELOW: begin
                        cmd.op     = agsb_pkg::OP_GAP_NEXT;
                        state_next = agsb_pkg::FSM_GAP_RD;
                    end
                    agsb_pkg::GC_ABOVE: begin
                        state_next = agsb_pkg::FSM_RESULT;
                    end
                    agsb_pkg::GC_COVER: begin
                        cmd.op     = agsb_pkg::OP_DEL_START;
                        state_next = agsb_pkg::FSM_DEL_CHK;
                    end
                    agsb_pkg::GC_FRONT: begin
                        cmd.op     = agsb_pkg::OP_TRIM_FRONT;
                        state_next = agsb_pkg::FSM_GAP_RD;
                    end
                    agsb_pkg::GC_BACK: begin
                        cmd.op     = agsb_pkg::OP_TRIM_BACK;
                        state_next = agsb_pkg::FSM_GAP_RD;
                    end
                    default: begin
                        if (stat.gap_full) begin
                            cmd.op     = agsb_pkg::OP_SET_GAP_FULL;
                            state_next = agsb_pkg::FSM_RESULT;
                        end else begin
                            cmd.op     = agsb_pkg::OP_SPLIT_SAVE;
                            state_next = agsb_pkg::FSM_INS_CHK;
                        end
                    end
                endcase
            end
            agsb_pkg::FSM_DEL_CHK: begin
                if (stat.del_more) begin
                    cmd.op     = agsb_pkg::OP_DEL_RD;
                    state_next = agsb_pkg::FSM_DEL_WR;
                end else begin
                    cmd.op     = agsb_pkg::OP_DEL_DONE;
                    state_next = agsb_pkg::FSM_GAP_RD;
                end
            end
            agsb_pkg::FSM_DEL_WR: begin
                cmd.op     = agsb_pkg::OP_DEL_WR;
                state_next = agsb_pkg::FSM_DEL_CHK;
            end
            agsb_pkg::FSM_INS_CHK: begin
                if (stat.ins_more) begin
                    cmd.op     = agsb_pkg::OP_INS_RD;
                    state_next = agsb_pkg::FSM_INS_WR;
                end else begin
                    cmd.op     = agsb_pkg::OP_INS_HI;
                    state_next = agsb_pkg::FSM_INS_LO;
                end
            end
            agsb_pkg::FSM_INS_WR: begin
                cmd.op     = agsb_pkg::OP_INS_WR;
                state_next = agsb_pkg::FSM_INS_CHK;
            end
            agsb_pkg::FSM_INS_LO: begin
                cmd.op     = agsb_pkg::OP_INS_LO;
                state_next = agsb_pkg::FSM_GAP_RD;
            end
            agsb_pkg::FSM_Q_RD: begin
                if (stat.gap_none) begin
                    state_next = agsb_pkg::FSM_RESULT;
                end else begin
                    cmd.op     = agsb_pkg::OP_GAP_RD;
                    state_next = agsb_pkg::FSM_Q_LD;
                end
            end
            agsb_pkg::FSM_Q_LD: begin
                cmd.op     = agsb_pkg::OP_Q_LOAD;
                state_next = agsb_pkg::FSM_Q_PC;
            end
            agsb_pkg::FSM_Q_PC: begin
                cmd.op     = agsb_pkg::OP_PIECE;
                state_next = agsb_pkg::FSM_OUT;
            end
            agsb_pkg::FSM_RESULT: begin
                cmd.op     = agsb_pkg::OP_FINAL;
                state_next = agsb_pkg::FSM_OUT;
            end
            agsb_pkg::FSM_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (stat.out_last) begin
                        state_next = agsb_pkg::FSM_IDLE;
                    end else begin
                        cmd.op     = agsb_pkg::OP_ADV;
                        state_next = stat.gap_done ? agsb_pkg::FSM_Q_RD : agsb_pkg::FSM_Q_PC;
                    end
                end
            end
            default: begin
                state_next = agsb_pkg::FSM_IDLE;
            end
        endcase

        // A query goes straight to the gap walk
        if (state_reg == agsb_pkg::FSM_IDLE && s_valid && !cfg_valid &&
            stat.mode == agsb_pkg::MODE_QUERY) begin
            state_next = agsb_pkg::FSM_Q_RD;
        end
    end

endmodule
